// ----- hw/rtl/xbs_pkg.sv -----
// Shared constants, codes and types for the XMODEM block sender.
package xbs_pkg;

    localparam int PAYLOAD_BYTES = 128;
    localparam int ADDR_W = $clog2(PAYLOAD_BYTES);
    localparam int CNT_W = $clog2(PAYLOAD_BYTES + 4) + 1;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(PAYLOAD_BYTES);
    localparam logic [CNT_W-1:0] HDR_BYTES = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_CKSUM = CNT_W'(3 + PAYLOAD_BYTES);

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_EOT = 8'h04;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_LINE  = 2'd2;
    localparam logic [1:0] CMD_REPLY = 2'd3;

    localparam logic [2:0] PH_FILL     = 3'd0;
    localparam logic [2:0] PH_SEND     = 3'd1;
    localparam logic [2:0] PH_WAIT     = 3'd2;
    localparam logic [2:0] PH_DONE     = 3'd3;
    localparam logic [2:0] PH_ERR      = 3'd4;
    localparam logic [2:0] PH_SEND_EOT = 3'd5;
    localparam logic [2:0] PH_WAIT_EOT = 3'd6;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       is_ack;
        logic       is_nak;
    } xbs_op_t;

endpackage

// ----- hw/rtl/xbs_in_if.sv -----
// Request channel carrying commands and their data bytes.
interface xbs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink (input valid, input command, input data_byte, output ready);
endinterface

// ----- hw/rtl/xbs_out_if.sv -----
// Result channel carrying one line byte and status per request.
interface xbs_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       load_refused;
    logic [2:0] status;

    modport source (output valid, output tx_valid, output tx_byte, output load_refused,
                    output status, input ready);
    modport sink (input valid, input tx_valid, input tx_byte, input load_refused,
                  input status, output ready);
endinterface

// ----- hw/rtl/xbs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module xbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/xbs_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
module xbs_front
    import xbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    xbs_in_if.sink   cmd_chan,
    output xbs_op_t  op,
    output logic     op_valid,
    input  logic     op_pop
);

    xbs_op_t           q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    xbs_op_t           new_op;

    assign cmd_chan.ready = (count_reg != QCNT_W'(QDEPTH));
    assign push = cmd_chan.valid && cmd_chan.ready;

    always_comb
    begin
        new_op.kind   = cmd_chan.command;
        new_op.data   = cmd_chan.data_byte;
        new_op.is_ack = (cmd_chan.data_byte == CH_ACK);
        new_op.is_nak = (cmd_chan.data_byte == CH_NAK);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (op_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !op_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (op_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign op       = q_reg[rd_ptr_reg];
    assign op_valid = (count_reg != '0);

endmodule

// ----- hw/rtl/xbs_back.sv -----
// Back end: runs the sender protocol on queued requests and registers each result.
module xbs_back
    import xbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  xbs_op_t   op,
    input  logic      op_valid,
    output logic      op_pop,
    input  logic      cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    xbs_out_if.source res_chan
);

    logic [7:0]       pad_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [7:0]       num_reg, num_next;
    logic [7:0]       sum_reg, sum_next;
    logic [2:0]       phase_reg, phase_next;
    logic             end_reg, end_next;

    logic             out_valid_reg;
    logic             tx_valid_reg, tx_valid_next;
    logic [7:0]       tx_byte_reg, tx_byte_next;
    logic             refused_reg, refused_next;
    logic [2:0]       status_reg, status_next;

    logic             step;
    logic             ram_we;
    logic [7:0]       ram_rdata;
    logic [CNT_W-1:0] rd_pos;
    logic [CNT_W-1:0] pay_idx;
    logic [7:0]       pay_byte;

    assign step   = op_valid && (!out_valid_reg || res_chan.ready);
    assign op_pop = step;

    // The read address follows the next send position, so the registered
    // read data always matches the current position.
    assign rd_pos  = pos_next - HDR_BYTES;
    assign pay_idx = pos_reg - HDR_BYTES;
    assign pay_byte = (pay_idx < fill_reg) ? ram_rdata : pad_reg;

    xbs_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (op.data),
        .raddr (rd_pos[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        num_next      = num_reg;
        sum_next      = sum_reg;
        phase_next    = phase_reg;
        end_next      = end_reg;
        tx_valid_next = 1'b0;
        tx_byte_next  = 8'h00;
        refused_next  = 1'b0;
        ram_we        = 1'b0;
        if (step)
        begin
            unique case (op.kind)
                CMD_LOAD:
                begin
                    if (phase_reg == PH_FILL && !end_reg && fill_reg < FILL_FULL)
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        if (fill_next == FILL_FULL)
                        begin
                            pos_next   = '0;
                            sum_next   = 8'h00;
                            phase_next = PH_SEND;
                        end
                    end
                    else
                    begin
                        refused_next = 1'b1;
                    end
                end
                CMD_END:
                begin
                    if (!end_reg && phase_reg != PH_DONE && phase_reg != PH_ERR)
                    begin
                        end_next = 1'b1;
                        if (phase_reg == PH_FILL)
                        begin
                            if (fill_reg != '0)
                            begin
                                pos_next   = '0;
                                sum_next   = 8'h00;
                                phase_next = PH_SEND;
                            end
                            else
                            begin
                                phase_next = PH_SEND_EOT;
                            end
                        end
                    end
                end
                CMD_LINE:
                begin
                    if (phase_reg == PH_SEND)
                    begin
                        tx_valid_next = 1'b1;
                        if (pos_reg == CNT_W'(0))
                        begin
                            tx_byte_next = CH_SOH;
                        end
                        else if (pos_reg == CNT_W'(1))
                        begin
                            tx_byte_next = num_reg;
                        end
                        else if (pos_reg == CNT_W'(2))
                        begin
                            tx_byte_next = ~num_reg;
                        end
                        else if (pos_reg < POS_CKSUM)
                        begin
                            tx_byte_next = pay_byte;
                            sum_next     = sum_reg + pay_byte;
                        end
                        else
                        begin
                            tx_byte_next = sum_reg;
                        end
                        if (pos_reg >= POS_CKSUM)
                        begin
                            phase_next = PH_WAIT;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    else if (phase_reg == PH_SEND_EOT)
                    begin
                        tx_valid_next = 1'b1;
                        tx_byte_next  = CH_EOT;
                        phase_next    = PH_WAIT_EOT;
                    end
                end
                CMD_REPLY:
                begin
                    if (phase_reg == PH_WAIT)
                    begin
                        if (op.is_ack)
                        begin
                            num_next   = num_reg + 1'b1;
                            fill_next  = '0;
                            pos_next   = '0;
                            sum_next   = 8'h00;
                            phase_next = end_reg ? PH_SEND_EOT : PH_FILL;
                        end
                        else if (op.is_nak)
                        begin
                            pos_next   = '0;
                            sum_next   = 8'h00;
                            phase_next = PH_SEND;
                        end
                        else
                        begin
                            phase_next = PH_ERR;
                        end
                    end
                    else if (phase_reg == PH_WAIT_EOT)
                    begin
                        phase_next = op.is_ack ? PH_DONE : PH_ERR;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (phase_next)
            PH_SEND_EOT: status_next = PH_SEND;
            PH_WAIT_EOT: status_next = PH_WAIT;
            default:     status_next = phase_next;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg       <= 8'h00;
            fill_reg      <= '0;
            pos_reg       <= '0;
            num_reg       <= 8'h01;
            sum_reg       <= 8'h00;
            phase_reg     <= PH_FILL;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pad_reg <= cfg_wr_data;
            end
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            num_reg   <= num_next;
            sum_reg   <= sum_next;
            phase_reg <= phase_next;
            end_reg   <= end_next;
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            tx_valid_reg <= tx_valid_next;
            tx_byte_reg  <= tx_byte_next;
            refused_reg  <= refused_next;
            status_reg   <= status_next;
        end
    end

    assign res_chan.valid        = out_valid_reg;
    assign res_chan.tx_valid     = tx_valid_reg;
    assign res_chan.tx_byte      = tx_byte_reg;
    assign res_chan.load_refused = refused_reg;
    assign res_chan.status       = status_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("Fill count exceeds the block size.");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_CKSUM)
        else $error("Send position runs past the checksum.");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERR |=> phase_reg == PH_ERR)
        else $error("Protocol error state was left before reset.");

    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (phase_reg == PH_FILL && !end_reg))
        else $error("Block store written outside the filling phase.");

endmodule

// ----- hw/rtl/xmodem_block_sender.sv -----
// Top level of the XMODEM checksum block sender.
// A request's result is registered at the clock edge after the one that accepts it,
// when the queue is empty and the result channel is free.
// Throughput: one request per cycle while the result channel is ready, set by the
// single-step back end and the registered block store read, addressed one position ahead.
// Reset clears all control state and sets the block number to one and the pad byte to zero.
module xmodem_block_sender
    import xbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    xbs_in_if.sink     cmd_chan,
    xbs_out_if.source  res_chan,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    xbs_op_t op;
    logic    op_valid;
    logic    op_pop;

    xbs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_chan (cmd_chan),
        .op       (op),
        .op_valid (op_valid),
        .op_pop   (op_pop)
    );

    xbs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .op_valid    (op_valid),
        .op_pop      (op_pop),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_chan    (res_chan)
    );

endmodule
